[rtl/sde_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_pkg
// Shared types, sizes, codes and the key hash of the string dictionary encoder.
// ----------------------------------------------------------------------------
package sde_pkg;

    localparam int ENTRIES   = 1024;
    localparam int KEY_BYTES = 15;
    localparam int ID_W      = $clog2(ENTRIES);
    localparam int CNT_W     = ID_W + 1;
    localparam int RID_W     = 10;
    localparam int LEN_W     = 4;
    localparam int LO_W      = 64;
    localparam int HI_W      = 56;
    localparam int KEY_W     = LEN_W + HI_W + LO_W;
    localparam int SLOT_W    = 1 + ID_W + KEY_W;

    // operation codes
    localparam logic [1:0] OP_ENCODE  = 2'd0;
    localparam logic [1:0] OP_FIND    = 2'd1;
    localparam logic [1:0] OP_REVERSE = 2'd2;

    // status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        logic [1:0]       operation;
        logic [LO_W-1:0]  key_low;
        logic [HI_W-1:0]  key_high;
        logic [LEN_W-1:0] key_length;
        logic [RID_W-1:0] query_id;
    } t_req;

    typedef struct packed {
        logic [RID_W-1:0] result_id;
        logic [1:0]       status;
        logic [LO_W-1:0]  out_key_low;
        logic [HI_W-1:0]  out_key_high;
        logic [LEN_W-1:0] out_key_length;
    } t_rsp;

    // normalized key: length and bytes, unused bytes zero
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [HI_W-1:0]  hi;
        logic [LO_W-1:0]  lo;
    } t_key;

    // command from front to back
    typedef struct packed {
        logic [1:0]       op;
        t_key             key;
        t_id              hash;
        logic [RID_W-1:0] qid;
    } t_cmd;

    // forward table slot
    typedef struct packed {
        logic used;
        t_id  id;
        t_key key;
    } t_slot;

    // xor fold of the key into a slot index
    function automatic t_id hash_key(input t_key k);
        logic [KEY_W-1:0] v;
        logic [ID_W-1:0]  h;
        logic [ID_W:0]    e;
        v = k;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % ID_W] = h[i % ID_W] ^ v[i];
        end
        e = {1'b0, h};
        if (e >= CNT_W'(ENTRIES)) begin
            e = e - CNT_W'(ENTRIES);
        end
        return e[ID_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/string_dictionary_encoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// string_dictionary_encoder_top
// Dictionary encoder mapping keys of up to 15 bytes to dense ids and back.
// ----------------------------------------------------------------------------
// After reset the forward hash table is swept clear, one slot a cycle; no
// request is taken from the queue until the sweep is done. A request is held
// in a two-entry queue register until the lookup engine is idle and takes it.
// A reverse lookup of a known id reads the reverse table RAM; one of an
// unknown id, or an unused operation, answers ST_UNKNOWN with no table read;
// an encode or find reads its hash slot, then one more slot per step of linear
// probing in the forward table RAM (one slot read per cycle). The engine takes
// a new request only when its output register is empty or being read, and a
// held result sits there while up to two more requests wait in the queue.
module string_dictionary_encoder_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire sde_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sde_pkg::t_rsp      o_rsp
);

    logic          cmd_valid;
    logic          cmd_pop;
    sde_pkg::t_cmd cmd;

    // accept and classify
    sde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    // table lookup and update
    sde_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

[rtl/sde_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/sde_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_front
// Accepts requests, normalizes the key, hashes it and queues the command.
// ----------------------------------------------------------------------------
module sde_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire sde_pkg::t_req i_req,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_pop,
    output sde_pkg::t_cmd      o_cmd
);

    sde_pkg::t_cmd              cmd;
    logic [sde_pkg::LEN_W-1:0]  len;
    sde_pkg::t_cmd              r_q [2];
    logic                       r_wr;
    logic                       r_rd;
    logic [1:0]                 r_cnt;
    logic                       push;

    // clamp length, clear bytes past it, hash
    always_comb begin
        len = i_req.key_length;
        if (len > sde_pkg::LEN_W'(sde_pkg::KEY_BYTES)) begin
            len = sde_pkg::LEN_W'(sde_pkg::KEY_BYTES);
        end
        cmd.op      = i_req.operation;
        cmd.qid     = i_req.query_id;
        cmd.key.len = len;
        for (int b = 0; b < 8; b++) begin
            cmd.key.lo[8*b +: 8] = (sde_pkg::LEN_W'(b) < len) ? i_req.key_low[8*b +: 8] : 8'd0;
        end
        for (int b = 0; b < 7; b++) begin
            cmd.key.hi[8*b +: 8] = (sde_pkg::LEN_W'(b + 8) < len) ?
                                   i_req.key_high[8*b +: 8] : 8'd0;
        end
        cmd.hash = sde_pkg::hash_key(cmd.key);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/sde_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_engine
// Probes the forward table, inserts new keys, reads the reverse table.
// ----------------------------------------------------------------------------
module sde_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire sde_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sde_pkg::t_rsp      o_rsp
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_REV   = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [sde_pkg::CNT_W-1:0]  r_next_id, n_next_id;
    sde_pkg::t_cmd              r_cmd, n_cmd;
    sde_pkg::t_id               r_addr, n_addr;
    sde_pkg::t_id               r_probes, n_probes;
    sde_pkg::t_id               r_clr, n_clr;
    sde_pkg::t_rsp              r_out, n_out;
    logic                       r_out_vld, n_out_vld;
    logic                       out_free;

    logic                       hram_we;
    sde_pkg::t_id               hram_waddr;
    sde_pkg::t_slot             hram_wdata;
    logic [sde_pkg::SLOT_W-1:0] hram_rdata;
    sde_pkg::t_slot             slot;
    logic                       rram_we;
    sde_pkg::t_id               rram_raddr;
    logic [sde_pkg::KEY_W-1:0]  rram_rdata;
    sde_pkg::t_key              rkey;
    logic [31:0]                q32;

    sde_ram #(.WIDTH(sde_pkg::SLOT_W), .DEPTH(sde_pkg::ENTRIES)) u_fwd (
        .i_clk   (i_clk),
        .i_we    (hram_we),
        .i_waddr (hram_waddr),
        .i_wdata (hram_wdata),
        .i_raddr (n_addr),
        .o_rdata (hram_rdata)
    );

    sde_ram #(.WIDTH(sde_pkg::KEY_W), .DEPTH(sde_pkg::ENTRIES)) u_rev (
        .i_clk   (i_clk),
        .i_we    (rram_we),
        .i_waddr (r_next_id[sde_pkg::ID_W-1:0]),
        .i_wdata (r_cmd.key),
        .i_raddr (rram_raddr),
        .o_rdata (rram_rdata)
    );

    assign slot       = sde_pkg::t_slot'(hram_rdata);
    assign rkey       = sde_pkg::t_key'(rram_rdata);
    assign out_free   = !r_out_vld || i_ready;
    assign rram_raddr = sde_pkg::ID_W'(i_cmd.qid);
    assign q32        = 32'(i_cmd.qid);
    assign o_valid    = r_out_vld;
    assign o_rsp      = r_out;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_next_id  = r_next_id;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_probes   = r_probes;
        n_clr      = r_clr;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_ready;
        o_cmd_pop  = 1'b0;
        hram_we    = 1'b0;
        hram_waddr = r_addr;
        hram_wdata = '0;
        rram_we    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                hram_we    = 1'b1;
                hram_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == sde_pkg::ID_W'(sde_pkg::ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_out     = '0;
                    n_out.status = sde_pkg::ST_UNKNOWN;
                    case (i_cmd.op)
                        sde_pkg::OP_ENCODE, sde_pkg::OP_FIND: begin
                            n_addr   = i_cmd.hash;
                            n_probes = '0;
                            n_state  = S_PROBE;
                        end
                        sde_pkg::OP_REVERSE: begin
                            if (q32 < 32'(r_next_id)) begin
                                n_state = S_REV;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                n_out        = '0;
                n_out.status = sde_pkg::ST_UNKNOWN;
                if (slot.used && slot.key == r_cmd.key) begin
                    n_out.result_id = sde_pkg::RID_W'(slot.id);
                    n_out.status    = sde_pkg::ST_FOUND;
                    n_out_vld       = 1'b1;
                    n_state         = S_IDLE;
                end else if (!slot.used ||
                             r_probes == sde_pkg::ID_W'(sde_pkg::ENTRIES - 1)) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_cmd.op == sde_pkg::OP_ENCODE) begin
                        if (slot.used || r_next_id == sde_pkg::CNT_W'(sde_pkg::ENTRIES)) begin
                            n_out.status = sde_pkg::ST_FULL;
                        end else begin
                            // claim the empty slot and the next id
                            hram_we         = 1'b1;
                            hram_wdata.used = 1'b1;
                            hram_wdata.id   = r_next_id[sde_pkg::ID_W-1:0];
                            hram_wdata.key  = r_cmd.key;
                            rram_we         = 1'b1;
                            n_next_id       = r_next_id + 1'b1;
                            n_out.result_id = sde_pkg::RID_W'(r_next_id[sde_pkg::ID_W-1:0]);
                            n_out.status    = sde_pkg::ST_INSERTED;
                        end
                    end
                end else begin
                    // linear probe to the next slot
                    n_probes = r_probes + 1'b1;
                    if (r_addr == sde_pkg::ID_W'(sde_pkg::ENTRIES - 1)) begin
                        n_addr = '0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            S_REV: begin
                n_out.result_id      = r_cmd.qid;
                n_out.status         = sde_pkg::ST_FOUND;
                n_out.out_key_low    = rkey.lo;
                n_out.out_key_high   = rkey.hi;
                n_out.out_key_length = rkey.len;
                n_out_vld            = 1'b1;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_next_id <= '0;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next_id <= n_next_id;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_probes <= n_probes;
        r_out    <= n_out;
    end

    // checks
    a_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id <= sde_pkg::CNT_W'(sde_pkg::ENTRIES))
        else $error("id counter beyond table size");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_out_vld && !o_cmd_pop))
        else $error("activity during clearing pass");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && i_cmd_valid && out_free))
        else $error("command taken while busy");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_id != $past(r_next_id)) |-> (r_next_id == $past(r_next_id) + 1'b1))
        else $error("id counter skipped");

endmodule
`default_nettype wire
